/* src/rtc_pkg.sv */
package rtc_pkg;

  localparam int MAX_TRIANGLES_DEF = 64;
  localparam int FRAC_BITS_DEF     = 16;

  // coordinate, difference, product, cross and determinant widths
  localparam int CW  = 32;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int XW  = PW + 1;
  localparam int SPL = 34;
  localparam int HW  = XW - SPL;
  localparam int TW  = 102;

  localparam int TRI_W  = 9 * CW;
  localparam int IDX_W  = 10;
  localparam int TMAX_W = 31;

  localparam logic [TMAX_W-1:0] T_MAX = '1;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_CAST = 1'b1
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } rtc_tag_t;

endpackage

/* src/ray_triangle_closest_hit_top.sv */
// Closest ray/triangle hit over a store of up to MAX_TRIANGLES triangles in
// Q16.16 (FRAC_BITS) fixed point. A load word (command 0) writes the three
// vertices into a slot and gives no result; loads to slots at or above
// MAX_TRIANGLES are dropped. A cast word (command 1) returns one result
// word: the store is walked from slot 0, one triangle per cycle through an
// exact Cramer-rule pipeline and a one-bit-per-stage divider. With
// n = min(triangle_count, MAX_TRIANGLES), the cast issues the n triangles,
// drains the pipeline, does the hit point multiply and fills the output
// register (with n zero it goes straight to the multiply); the input is
// ready again once the result word is registered. The input takes no new
// word during a cast. The store has no reset: only slots that were loaded
// may be searched. The user must see that triangle_count is written only
// while idle; the block does not enforce it.
module ray_triangle_closest_hit_top import rtc_pkg::*; #(
  parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [6:0]            cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  command,
  input  logic [5:0]            slot,
  input  logic signed [CW-1:0]  a_x,
  input  logic signed [CW-1:0]  a_y,
  input  logic signed [CW-1:0]  a_z,
  input  logic signed [CW-1:0]  b_x,
  input  logic signed [CW-1:0]  b_y,
  input  logic signed [CW-1:0]  b_z,
  input  logic signed [CW-1:0]  c_x,
  input  logic signed [CW-1:0]  c_y,
  input  logic signed [CW-1:0]  c_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [5:0]            hit_slot,
  output logic [TMAX_W-1:0]     distance,
  output logic signed [CW-1:0]  hit_x,
  output logic signed [CW-1:0]  hit_y,
  output logic signed [CW-1:0]  hit_z
);

  localparam int AW   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CNTW = $clog2(MAX_TRIANGLES + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SWEEP = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_PMUL  = 5'b01000,
    ST_POINT = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [6:0]      triangle_count;
  logic [CNTW-1:0] n_cnt, idx;
  logic            in_fire, cast_fire, load_fire, slot_ok, issue_last, out_free;

  logic signed [CW-1:0] ray_s [3];
  logic signed [CW-1:0] ray_d [3];

  rtc_tag_t         iss_tag, rd_tag, det_tag, div_tag;
  logic [TRI_W-1:0] tri_rd;

  logic signed [TW-1:0] det, nt, nu, nv;
  logic                 div_hit;
  logic [TMAX_W-1:0]    div_t;

  logic              found;
  logic [TMAX_W-1:0] best_t;
  logic [IDX_W-1:0]  best_i;

  logic signed [2*CW-1:0] pt_prod [3];
  logic signed [CW-1:0]   pt_val  [3];

  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign cast_fire  = in_fire && (command == CMD_CAST);
  assign slot_ok    = 32'(slot) < MAX_TRIANGLES;
  assign load_fire  = in_fire && (command == CMD_LOAD) && slot_ok;
  assign issue_last = (idx == n_cnt - CNTW'(1));
  assign out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      triangle_count <= '0;
    end else if (cfg_wr_en) begin
      triangle_count <= cfg_wr_data;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cast_fire) begin
          state_next = (triangle_count == '0) ? ST_PMUL : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (div_tag.valid && div_tag.last) begin
          state_next = ST_PMUL;
        end
      end
      ST_PMUL: begin
        state_next = ST_POINT;
      end
      ST_POINT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      n_cnt <= '0;
    end else begin
      state <= state_next;
      if (cast_fire) begin
        idx   <= '0;
        n_cnt <= (32'(triangle_count) > MAX_TRIANGLES) ? CNTW'(MAX_TRIANGLES)
                                                       : CNTW'(triangle_count);
      end else if (state == ST_SWEEP) begin
        idx <= idx + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cast_fire) begin
      ray_s[0] <= a_x;
      ray_s[1] <= a_y;
      ray_s[2] <= a_z;
      ray_d[0] <= b_x;
      ray_d[1] <= b_y;
      ray_d[2] <= b_z;
    end
  end

  // triangle store, one slot per row
  rtc_ram #(
    .WIDTH (TRI_W),
    .DEPTH (MAX_TRIANGLES)
  ) u_store (
    .clk   (clk),
    .we    (load_fire),
    .waddr (AW'(slot)),
    .wdata ({c_z, c_y, c_x, b_z, b_y, b_x, a_z, a_y, a_x}),
    .raddr (idx[AW-1:0]),
    .rdata (tri_rd)
  );

  assign iss_tag.valid = (state == ST_SWEEP);
  assign iss_tag.last  = issue_last;
  assign iss_tag.idx   = IDX_W'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag <= '0;
    end else begin
      rd_tag <= iss_tag;
    end
  end

  rtc_det u_det (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (rd_tag),
    .tri_in  (tri_rd),
    .ray_s   (ray_s),
    .ray_d   (ray_d),
    .tag_out (det_tag),
    .det     (det),
    .nt      (nt),
    .nu      (nu),
    .nv      (nv)
  );

  rtc_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (det_tag),
    .det     (det),
    .nt      (nt),
    .nu      (nu),
    .nv      (nv),
    .tag_out (div_tag),
    .hit     (div_hit),
    .t       (div_t)
  );

  // closest hit, first slot wins ties
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cast_fire) begin
      found <= 1'b0;
    end else if (div_tag.valid && div_hit) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_tag.valid && div_hit && (!found || div_t < best_t)) begin
      best_t <= div_t;
      best_i <= div_tag.idx;
    end
  end

  // hit point
  always_ff @(posedge clk) begin
    if (state == ST_PMUL) begin
      for (int k = 0; k < 3; k++) begin
        pt_prod[k] <= (2*CW)'($signed({1'b0, best_t})) * (2*CW)'(ray_d[k]);
      end
    end
  end

  always_comb begin
    logic signed [2*CW:0] v;
    for (int k = 0; k < 3; k++) begin
      v = (2*CW+1)'(ray_s[k]) + (2*CW+1)'(pt_prod[k] >>> FRAC_BITS);
      if (v[2*CW:CW-1] != {(CW+2){v[CW-1]}}) begin
        pt_val[k] = v[2*CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        pt_val[k] = v[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_POINT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_POINT && out_free) begin
      hit      <= found;
      hit_slot <= found ? 6'(best_i) : '0;
      distance <= found ? best_t : T_MAX;
      hit_x    <= found ? pt_val[0] : '0;
      hit_y    <= found ? pt_val[1] : '0;
      hit_z    <= found ? pt_val[2] : '0;
    end
  end

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_tag.valid && !det_tag.valid && !rd_tag.valid)
    else $error("pipeline word while idle");

  a_last_in_drain: assert property (@(posedge clk) disable iff (rst)
    (div_tag.valid && div_tag.last) |-> (state == ST_DRAIN))
    else $error("last triangle outside drain");

  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (idx < n_cnt))
    else $error("slot index beyond count");

  a_result_after_point: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_POINT))
    else $error("result without point stage");
`endif

endmodule

/* src/rtc_ram.sv */
module rtc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/rtc_det.sv */
module rtc_det import rtc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  rtc_tag_t             tag_in,
  input  logic [TRI_W-1:0]     tri_in,
  input  logic signed [CW-1:0] ray_s [3],
  input  logic signed [CW-1:0] ray_d [3],
  output rtc_tag_t             tag_out,
  output logic signed [TW-1:0] det,
  output logic signed [TW-1:0] nt,
  output logic signed [TW-1:0] nu,
  output logic signed [TW-1:0] nv
);

  localparam int PH_W = DW + HW;
  localparam int PL_W = DW + SPL + 1;

  // vectors: 0 -d, 1 e1, 2 e2, 3 b
  localparam int QI [3] = '{1, 3, 1};
  localparam int RI [3] = '{2, 2, 3};
  localparam int PI [4] = '{0, 3, 0, 0};
  localparam int CI [4] = '{0, 0, 1, 2};

  rtc_tag_t tag_p [6];

  logic signed [DW-1:0]   va   [4][3];
  logic signed [DW-1:0]   vb   [4][3];
  logic signed [DW-1:0]   vc   [4][3];
  logic signed [PW-1:0]   pa   [3][3];
  logic signed [PW-1:0]   pb   [3][3];
  logic signed [XW-1:0]   xc   [3][3];
  logic signed [PH_W-1:0] ph   [4][3];
  logic signed [PL_W-1:0] pl   [4][3];
  logic signed [TW-1:0]   term [4][3];
  logic signed [TW-1:0]   sum  [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        tag_p[i] <= '0;
      end
    end else begin
      tag_p[0] <= tag_in;
      for (int i = 1; i < 6; i++) begin
        tag_p[i] <= tag_p[i-1];
      end
    end
  end

  // edges and offset
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      va[0][j] <= -DW'(ray_d[j]);
      va[1][j] <= DW'($signed(tri_in[(3+j)*CW +: CW])) - DW'($signed(tri_in[j*CW +: CW]));
      va[2][j] <= DW'($signed(tri_in[(6+j)*CW +: CW])) - DW'($signed(tri_in[j*CW +: CW]));
      va[3][j] <= DW'(ray_s[j]) - DW'($signed(tri_in[j*CW +: CW]));
    end
    vb <= va;
    vc <= vb;
  end

  // cross products: e1 x e2, b x e2, e1 x b
  for (genvar c = 0; c < 3; c++) begin : g_cross
    for (genvar j = 0; j < 3; j++) begin : g_comp
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      always_ff @(posedge clk) begin
        pa[c][j] <= PW'(va[QI[c]][J1]) * PW'(va[RI[c]][J2]);
        pb[c][j] <= PW'(va[QI[c]][J2]) * PW'(va[RI[c]][J1]);
        xc[c][j] <= XW'(pa[c][j]) - XW'(pb[c][j]);
      end
    end
  end

  // dot products, split into two partial products per term
  for (genvar m = 0; m < 4; m++) begin : g_dot
    for (genvar j = 0; j < 3; j++) begin : g_term
      always_ff @(posedge clk) begin
        ph[m][j]   <= PH_W'(vc[PI[m]][j]) * PH_W'($signed(xc[CI[m]][j][XW-1:SPL]));
        pl[m][j]   <= PL_W'(vc[PI[m]][j]) * PL_W'($signed({1'b0, xc[CI[m]][j][SPL-1:0]}));
        term[m][j] <= (TW'(ph[m][j]) <<< SPL) + TW'(pl[m][j]);
      end
    end
    always_ff @(posedge clk) begin
      sum[m] <= term[m][0] + term[m][1] + term[m][2];
    end
  end

  assign tag_out = tag_p[5];
  assign det     = sum[0];
  assign nt      = sum[1];
  assign nu      = sum[2];
  assign nv      = sum[3];

endmodule

/* src/rtc_div.sv */
module rtc_div import rtc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rtc_tag_t             tag_in,
  input  logic signed [TW-1:0] det,
  input  logic signed [TW-1:0] nt,
  input  logic signed [TW-1:0] nu,
  input  logic signed [TW-1:0] nv,
  output rtc_tag_t             tag_out,
  output logic                 hit,
  output logic [TMAX_W-1:0]    t
);

  localparam int QW  = TW + FRAC_BITS + 32;
  localparam int NST = TMAX_W;

  rtc_tag_t             tag_n0;
  logic signed [TW-1:0] dn, tn, un, vn;
  logic                 zero;

  rtc_tag_t          tag_r [NST+1];
  logic              hit_r [NST+1];
  logic              sat_r [NST+1];
  logic [TMAX_W-1:0] q_r   [NST+1];
  logic [QW-1:0]     rem_r [NST];
  logic [TW-1:0]     den_r [NST];

  // sign normalize so the determinant is not negative
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_n0 <= '0;
    end else begin
      tag_n0 <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    zero <= (det == '0);
    if (det[TW-1]) begin
      dn <= -det;
      tn <= -nt;
      un <= -nu;
      vn <= -nv;
    end else begin
      dn <= det;
      tn <= nt;
      un <= nu;
      vn <= nv;
    end
  end

  // inside test and saturation check
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_r[0] <= '0;
    end else begin
      tag_r[0] <= tag_n0;
    end
  end

  always_ff @(posedge clk) begin
    hit_r[0] <= !zero && !tn[TW-1] && !un[TW-1] && !vn[TW-1] &&
                ((TW+1)'(un) + (TW+1)'(vn) <= (TW+1)'(dn));
    sat_r[0] <= (QW'($unsigned(tn)) << FRAC_BITS) >= (QW'($unsigned(dn)) << TMAX_W);
    rem_r[0] <= QW'($unsigned(tn)) << FRAC_BITS;
    den_r[0] <= dn;
    q_r[0]   <= '0;
  end

  // restoring division, one quotient bit per stage
  for (genvar g = 0; g < NST; g++) begin : g_stage
    localparam int K = NST - 1 - g;
    logic [QW-1:0] sub;
    logic          take;

    assign sub  = QW'(den_r[g]) << K;
    assign take = rem_r[g] >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_r[g+1] <= '0;
      end else begin
        tag_r[g+1] <= tag_r[g];
      end
    end

    always_ff @(posedge clk) begin
      hit_r[g+1] <= hit_r[g];
      sat_r[g+1] <= sat_r[g];
      q_r[g+1]   <= take ? (q_r[g] | (TMAX_W'(1) << K)) : q_r[g];
    end

    if (g < NST - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[g+1] <= take ? (rem_r[g] - sub) : rem_r[g];
        den_r[g+1] <= den_r[g];
      end
    end
  end

  assign tag_out = tag_r[NST];
  assign hit     = hit_r[NST];
  assign t       = sat_r[NST] ? T_MAX : q_r[NST];

endmodule

/* tb/ray_triangle_closest_hit_checker.sv */
`timescale 1ns / 1ps

module ray_triangle_closest_hit_checker import rtc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [6:0]           cfg_wr_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 command,
  input  logic [5:0]           slot,
  input  logic signed [CW-1:0] a_x,
  input  logic signed [CW-1:0] a_y,
  input  logic signed [CW-1:0] a_z,
  input  logic signed [CW-1:0] b_x,
  input  logic signed [CW-1:0] b_y,
  input  logic signed [CW-1:0] b_z,
  input  logic signed [CW-1:0] c_x,
  input  logic signed [CW-1:0] c_y,
  input  logic signed [CW-1:0] c_z,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 hit,
  input  logic [5:0]           hit_slot,
  input  logic [TMAX_W-1:0]    distance,
  input  logic signed [CW-1:0] hit_x,
  input  logic signed [CW-1:0] hit_y,
  input  logic signed [CW-1:0] hit_z,
  output int                   errors,
  output int                   pending,
  output int                   casts_seen,
  output int                   hits_seen
);

  typedef struct {
    logic                 hit;
    logic [5:0]           idx;
    logic [TMAX_W-1:0]    t_q;
    logic signed [CW-1:0] p [3];
  } hit_word_t;

  logic signed [CW-1:0] tri_store [MAX_TRIANGLES_DEF][9];
  logic [6:0]           tri_count;
  hit_word_t            hit_q [$];

  function automatic logic signed [127:0] triple(
    input logic signed [127:0] p [3], input logic signed [127:0] q [3],
    input logic signed [127:0] r [3]);
    return p[0] * (q[1] * r[2] - q[2] * r[1]) + p[1] * (q[2] * r[0] - q[0] * r[2])
         + p[2] * (q[0] * r[1] - q[1] * r[0]);
  endfunction

  function automatic hit_word_t closest_hit(input logic signed [CW-1:0] s [3],
                                            input logic signed [CW-1:0] d [3]);
    hit_word_t             w;
    logic signed [127:0]   nd [3], e1 [3], e2 [3], bv [3], v0 [3];
    logic signed [127:0]   det, nt, nu, nv;
    logic [159:0]          num_w, den_w, quo;
    logic [TMAX_W-1:0]     t, best_t;
    logic signed [63:0]    prod, pv;
    int                    n, best_i;
    bit                    found;
    found = 0;
    best_t = T_MAX;
    best_i = 0;
    n = (tri_count > MAX_TRIANGLES_DEF) ? MAX_TRIANGLES_DEF : tri_count;
    for (int k = 0; k < 3; k++) nd[k] = -128'(d[k]);
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++) begin
        v0[k] = tri_store[i][k];
        e1[k] = 128'(tri_store[i][3+k]) - v0[k];
        e2[k] = 128'(tri_store[i][6+k]) - v0[k];
        bv[k] = 128'(s[k]) - v0[k];
      end
      det = triple(nd, e1, e2);
      if (det == 0) continue;
      nt = triple(bv, e1, e2);
      nu = triple(nd, bv, e2);
      nv = triple(nd, e1, bv);
      if (det < 0) begin
        det = -det; nt = -nt; nu = -nu; nv = -nv;
      end
      if (nt < 0 || nu < 0 || nv < 0) continue;
      if (nu + nv > det) continue;
      num_w = 160'(nt) << FRAC_BITS_DEF;
      den_w = 160'(det);
      quo = num_w / den_w;
      t = (quo > 160'(T_MAX)) ? T_MAX : quo[TMAX_W-1:0];
      if (!found || t < best_t) begin
        found = 1;
        best_t = t;
        best_i = i;
      end
    end
    w.hit = found;
    w.idx = found ? best_i[5:0] : '0;
    w.t_q = best_t;
    for (int k = 0; k < 3; k++) begin
      prod = $signed({33'b0, best_t}) * 64'(d[k]);
      pv = 64'(s[k]) + (prod >>> FRAC_BITS_DEF);
      if (pv > 64'sd2147483647) pv = 64'sd2147483647;
      if (pv < -64'sd2147483648) pv = -64'sd2147483648;
      w.p[k] = found ? pv[31:0] : '0;
    end
    return w;
  endfunction

  assign pending = hit_q.size();

  always @(posedge clk) begin
    hit_word_t            exp_w;
    logic signed [CW-1:0] s [3], d [3], got_p [3];
    if (rst) begin
      tri_count <= '0;
      hit_q.delete();
      errors <= 0;
      casts_seen <= 0;
      hits_seen <= 0;
    end else begin
      if (cfg_wr_en) tri_count <= cfg_wr_data;
      if (out_valid && out_ready) begin
        got_p = '{hit_x, hit_y, hit_z};
        if (hit_q.size() == 0) begin
          $display("%0t: result word with none expected: got hit=%0b idx=%0d", $time,
                   hit, hit_slot);
          errors <= errors + 1;
        end else begin
          exp_w = hit_q.pop_front();
          if (hit != exp_w.hit || hit_slot != exp_w.idx || distance != exp_w.t_q
              || got_p[0] != exp_w.p[0] || got_p[1] != exp_w.p[1]
              || got_p[2] != exp_w.p[2]) begin
            $display("%0t: mismatch expected hit=%0b idx=%0d t=%h p=%h %h %h", $time,
                     exp_w.hit, exp_w.idx, exp_w.t_q, exp_w.p[0], exp_w.p[1], exp_w.p[2]);
            $display("%0t:          actual   hit=%0b idx=%0d t=%h p=%h %h %h", $time,
                     hit, hit_slot, distance, hit_x, hit_y, hit_z);
            errors <= errors + 1;
          end
          if (exp_w.hit) hits_seen <= hits_seen + 1;
        end
      end
      if (in_valid && in_ready) begin
        if (cmd_t'(command) == CMD_LOAD) begin
          tri_store[slot] <= '{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z};
        end else begin
          s = '{a_x, a_y, a_z};
          d = '{b_x, b_y, b_z};
          hit_q.push_back(closest_hit(s, d));
          casts_seen <= casts_seen + 1;
        end
      end
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb import rtc_pkg::*;;

  localparam logic signed [CW-1:0] ONE = 32'sh10000;
  localparam logic signed [CW-1:0] SMIN = 32'sh80000000;
  localparam logic signed [CW-1:0] SMAX = 32'sh7fffffff;
  localparam int IDLE_LIMIT = 3000;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 cfg_wr_en = 0;
  logic [6:0]           cfg_wr_data = '0;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic                 command = 0;
  logic [5:0]           slot = '0;
  logic signed [CW-1:0] a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0;
  logic signed [CW-1:0] c_x = 0, c_y = 0, c_z = 0;
  logic                 out_valid;
  logic                 out_ready = 0;
  logic                 hit;
  logic [5:0]           hit_slot;
  logic [TMAX_W-1:0]    distance;
  logic signed [CW-1:0] hit_x, hit_y, hit_z;

  int errors, pending, casts_seen, hits_seen;
  int burst_left = 0;
  int hold_req = 0;
  int idle_cycles = 0;
  logic signed [CW-1:0] tri_copy [64][9];

  always #6 clk = ~clk;

  ray_triangle_closest_hit_top dut (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_ready, .command, .slot,
    .a_x, .a_y, .a_z, .b_x, .b_y, .b_z, .c_x, .c_y, .c_z,
    .out_valid, .out_ready, .hit, .hit_slot, .distance, .hit_x, .hit_y, .hit_z
  );

  ray_triangle_closest_hit_checker chk (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_ready, .command, .slot,
    .a_x, .a_y, .a_z, .b_x, .b_y, .b_z, .c_x, .c_y, .c_z,
    .out_valid, .out_ready, .hit, .hit_slot, .distance, .hit_x, .hit_y, .hit_z,
    .errors, .pending, .casts_seen, .hits_seen
  );

  // receiver stall pattern plus long hold-off on request
  always @(negedge clk) begin
    int hold_cnt, cyc;
    if (hold_cnt > 0) begin
      out_ready = 0;
      hold_cnt--;
    end else if (hold_req != 0) begin
      hold_req = 0;
      hold_cnt = 400;
      out_ready = 0;
    end else begin
      case ((cyc / 200) % 4)
        0: out_ready = 1;
        1: out_ready = ($urandom_range(0, 1) == 1);
        2: out_ready = ($urandom_range(0, 9) != 0);
        default: out_ready = ($urandom_range(0, 4) == 0);
      endcase
    end
    cyc++;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_word(input cmd_t cmd, input logic [5:0] s,
                           input logic signed [CW-1:0] v [9]);
    if (burst_left == 0) begin
      in_valid = 0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    command = cmd;
    slot = s;
    {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = {v[0], v[1], v[2], v[3], v[4], v[5],
                                                     v[6], v[7], v[8]};
    in_valid = 1;
    if (cmd == CMD_LOAD) tri_copy[s] = v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic set_count(input logic [6:0] n);
    in_valid = 0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    cfg_wr_data = n;
    cfg_wr_en = 1;
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  function automatic logic signed [CW-1:0] box_coord();
    return $signed($urandom_range(0, 16 << 16)) - (8 <<< 16);
  endfunction

  function automatic logic signed [CW-1:0] rnd32();
    return $signed($urandom());
  endfunction

  task automatic random_word();
    logic signed [CW-1:0] v [9];
    longint cen, off;
    int pick, src;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      for (int k = 0; k < 9; k++) v[k] = ($urandom_range(0, 3) == 0) ? rnd32() : box_coord();
      if (pick < 4) begin
        src = $urandom_range(0, 63);
        v = tri_copy[src];
      end
      send_word(CMD_LOAD, 6'($urandom()), v);
    end else begin
      for (int k = 0; k < 9; k++) v[k] = rnd32();
      if (pick < 80) begin
        // aim at a random stored triangle from a random offset
        src = $urandom_range(0, 63);
        for (int k = 0; k < 3; k++) begin
          cen = (longint'(tri_copy[src][k]) + tri_copy[src][3+k] + tri_copy[src][6+k]) / 3;
          off = longint'($signed($urandom_range(0, 8 << 16))) - (4 <<< 16);
          v[k] = 32'(cen + off);
          v[3+k] = 32'(-off / longint'($urandom_range(1, 4)));
        end
      end else if (pick < 90) begin
        for (int k = 0; k < 6; k++) v[k] = box_coord();
      end
      send_word(CMD_CAST, 6'($urandom()), v);
    end
  endtask

  initial begin
    logic signed [CW-1:0] v [9];
    logic [6:0] n;
    for (int i = 0; i < 64; i++) for (int k = 0; k < 9; k++) tri_copy[i][k] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // empty store searched: no hit
    send_word(CMD_CAST, 6'd0, '{ONE, ONE, ONE, 0, 0, -ONE, 0, 0, 0});
    send_word(CMD_LOAD, 6'd0, '{0, 0, 0, ONE, 0, 0, 0, ONE, 0});
    send_word(CMD_LOAD, 6'd1, '{0, 0, -2*ONE, ONE, 0, -2*ONE, 0, ONE, -2*ONE});
    send_word(CMD_LOAD, 6'd2, '{3*ONE, 3*ONE, 3*ONE, 3*ONE, 3*ONE, 3*ONE, 3*ONE, 3*ONE,
                                3*ONE});
    send_word(CMD_LOAD, 6'd3, '{SMIN, SMIN, 0, SMAX, SMIN, 0, SMIN, SMAX, 0});
    send_word(CMD_LOAD, 6'd63, '{SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, -1, -1, -1});
    set_count(7'd4);
    send_word(CMD_CAST, 6'd0, '{ONE/4, ONE/4, 5*ONE, 0, 0, -ONE, 0, 0, 0});
    send_word(CMD_CAST, 6'd63, '{ONE/4, ONE/4, 5*ONE, ONE, 0, 0, SMAX, SMIN, -1});
    send_word(CMD_CAST, 6'd0, '{ONE/2, ONE/2, 5*ONE, 0, 0, -ONE, 0, 0, 0});
    send_word(CMD_CAST, 6'd0, '{ONE/4, ONE/4, -5*ONE, 0, 0, -ONE, 0, 0, 0});
    send_word(CMD_CAST, 6'd0, '{ONE/4, ONE/4, -ONE, 0, 0, -ONE, 0, 0, 0});
    send_word(CMD_CAST, 6'd0, '{100*ONE, 100*ONE, 32'sh7fff0000, 0, 0, -1, 0, 0, 0});
    send_word(CMD_CAST, 6'd21, '{SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, -1, -1, -1});
    send_word(CMD_CAST, 6'd42, '{2*ONE, 2*ONE, 5*ONE, 0, 0, -ONE, 0, 0, 0});
    send_word(CMD_CAST, 6'd0, '{-ONE, -ONE, ONE, ONE, ONE, -ONE, 0, 0, 0});

    // fill the whole store so any count is legal from here on
    for (int i = 0; i < 64; i++) begin
      for (int k = 0; k < 9; k++) v[k] = ($urandom_range(0, 4) == 0) ? rnd32() : box_coord();
      send_word(CMD_LOAD, 6'(i), v);
    end
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: n = 7'd64;
        1: n = 7'd127;
        2: n = 7'd0;
        3: n = 7'd1;
        default: n = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                 : 7'($urandom_range(1, 16));
      endcase
      set_count(n);
      for (int i = 0; i < 42; i++) begin
        if ((ph == 4 || ph == 8) && i == 5) hold_req = 1;
        random_word();
      end
    end

    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    $display("covered %0d rays (%0d hits) over counts 0, 1, 4, 64, 127 and random ones,",
             casts_seen, hits_seen);
    $display("with random loads, receiver hold-offs and sender bursts");
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
